/* rtl/dwr_pkg.sv */
// types, constants and microcode table for the draw-without-replacement block
`timescale 1ns / 1ps
`default_nettype none

package dwr_pkg;

    localparam int POOL_DEPTH_DEF = 1024;
    localparam int VALUE_W = 32;
    localparam int WORD_W = 15;
    localparam int COUNT_W = 11;
    localparam int STATUS_W = 3;
    localparam int MOD_CNT_W = $clog2(WORD_W);
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_START = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_END = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRAW_COUNT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COUNT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd5;

    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP = 4'd0;
    localparam logic [OP_W-1:0] OP_LATCH = 4'd1;
    localparam logic [OP_W-1:0] OP_CHECK_CFG = 4'd2;
    localparam logic [OP_W-1:0] OP_FILL = 4'd3;
    localparam logic [OP_W-1:0] OP_START_RUN = 4'd4;
    localparam logic [OP_W-1:0] OP_CHECK_DRAW = 4'd5;
    localparam logic [OP_W-1:0] OP_MOD_STEP = 4'd6;
    localparam logic [OP_W-1:0] OP_RD_PICK = 4'd7;
    localparam logic [OP_W-1:0] OP_RD_TAIL = 4'd8;
    localparam logic [OP_W-1:0] OP_WR_PICK = 4'd9;
    localparam logic [OP_W-1:0] OP_WR_TAIL = 4'd10;
    localparam logic [OP_W-1:0] OP_EMIT = 4'd11;

    // jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEXT = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS = 3'd1;
    localparam logic [COND_W-1:0] C_DISPATCH = 3'd2;
    localparam logic [COND_W-1:0] C_CFG_FAIL = 3'd3;
    localparam logic [COND_W-1:0] C_DRAW_FAIL = 3'd4;
    localparam logic [COND_W-1:0] C_FILL_MORE = 3'd5;
    localparam logic [COND_W-1:0] C_MOD_MORE = 3'd6;

    // microprogram steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] S_R_CHECK = 4'd1;
    localparam logic [STEP_W-1:0] S_R_FILL = 4'd2;
    localparam logic [STEP_W-1:0] S_R_RUN = 4'd3;
    localparam logic [STEP_W-1:0] S_D_CHECK = 4'd4;
    localparam logic [STEP_W-1:0] S_D_MOD = 4'd5;
    localparam logic [STEP_W-1:0] S_D_RD_PICK = 4'd6;
    localparam logic [STEP_W-1:0] S_D_RD_TAIL = 4'd7;
    localparam logic [STEP_W-1:0] S_D_WR_PICK = 4'd8;
    localparam logic [STEP_W-1:0] S_D_WR_TAIL = 4'd9;
    localparam logic [STEP_W-1:0] S_OUT = 4'd10;

    typedef struct packed {
        logic                command;
        logic [WORD_W-1:0]   random_word;
    } request_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  drawn_value;
        logic [STATUS_W-1:0] status;
        logic                last_draw;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [COND_W-1:0]   cond;
        logic [STEP_W-1:0]   target;
    } ucode_t;

    typedef struct packed {
        logic cfg_fail;
        logic draw_fail;
        logic fill_more;
        logic mod_more;
    } dp_flags_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
        unique case (step)
            S_IDLE:      w = '{op: OP_LATCH,      cond: C_DISPATCH,  target: S_IDLE};
            S_R_CHECK:   w = '{op: OP_CHECK_CFG,  cond: C_CFG_FAIL,  target: S_OUT};
            S_R_FILL:    w = '{op: OP_FILL,       cond: C_FILL_MORE, target: S_R_FILL};
            S_R_RUN:     w = '{op: OP_START_RUN,  cond: C_ALWAYS,    target: S_OUT};
            S_D_CHECK:   w = '{op: OP_CHECK_DRAW, cond: C_DRAW_FAIL, target: S_OUT};
            S_D_MOD:     w = '{op: OP_MOD_STEP,   cond: C_MOD_MORE,  target: S_D_MOD};
            S_D_RD_PICK: w = '{op: OP_RD_PICK,    cond: C_NEXT,      target: S_IDLE};
            S_D_RD_TAIL: w = '{op: OP_RD_TAIL,    cond: C_NEXT,      target: S_IDLE};
            S_D_WR_PICK: w = '{op: OP_WR_PICK,    cond: C_NEXT,      target: S_IDLE};
            S_D_WR_TAIL: w = '{op: OP_WR_TAIL,    cond: C_NEXT,      target: S_IDLE};
            S_OUT:       w = '{op: OP_EMIT,       cond: C_ALWAYS,    target: S_IDLE};
            default:     w = '{op: OP_NOP,        cond: C_ALWAYS,    target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/dwr_useq.sv */
// microcode sequencer: step counter, control store and jump logic
`timescale 1ns / 1ps
`default_nettype none

module dwr_useq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              command,
    input  wire dwr_pkg::dp_flags_t flags,
    output dwr_pkg::ucode_t        ctl,
    output logic                   busy,
    output logic                   done
);
    import dwr_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic [STEP_W-1:0] step_inc;
    logic              taken;

    assign word = ucode_rom(step_reg);
    assign step_inc = step_reg + 1'b1;
    assign busy = (step_reg != S_IDLE);
    assign done = (word.op == OP_EMIT);

    always_comb
    begin
        ctl = word;
        if (word.op == OP_LATCH && !start)
        begin
            ctl.op = OP_NOP;
        end
    end

    always_comb
    begin
        taken = 1'b0;
        step_next = step_inc;
        unique case (word.cond)
            C_NEXT:      taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_CFG_FAIL:  taken = flags.cfg_fail;
            C_DRAW_FAIL: taken = flags.draw_fail;
            C_FILL_MORE: taken = flags.fill_more;
            C_MOD_MORE:  taken = flags.mod_more;
            default:     taken = 1'b0;
        endcase
        if (taken)
        begin
            step_next = word.target;
        end
        if (word.cond == C_DISPATCH)
        begin
            if (!start)
            begin
                step_next = step_reg;
            end
            else if (command == CMD_DRAW)
            begin
                step_next = S_D_CHECK;
            end
            else
            begin
                step_next = S_R_CHECK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/dwr_datapath.sv */
// datapath: configuration, run state, bit-serial modulo and offset pool memory
`timescale 1ns / 1ps
`default_nettype none

module dwr_datapath #(
    parameter int POOL_DEPTH = dwr_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [dwr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dwr_pkg::VALUE_W-1:0]   cfg_data,
    input  wire logic [dwr_pkg::WORD_W-1:0]    random_word,
    input  wire dwr_pkg::ucode_t               ctl,
    output dwr_pkg::dp_flags_t                 flags,
    output dwr_pkg::result_t                   result
);
    import dwr_pkg::*;

    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int SW = VALUE_W + 1;

    logic [VALUE_W-1:0]  range_start_reg;
    logic [VALUE_W-1:0]  range_end_reg;
    logic [COUNT_W-1:0]  draw_count_reg;
    logic                run_valid_reg;
    logic [COUNT_W-1:0]  draws_done_reg;

    logic [WORD_W-1:0]   word_reg;
    logic [AW-1:0]       cnt_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;
    logic [AW-1:0]       rem_reg;
    logic [AW:0]         left_reg;
    logic [AW-1:0]       tail_reg;
    logic [AW-1:0]       chosen_reg;
    logic [AW-1:0]       rd_data_reg;

    logic [VALUE_W-1:0]  value_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    logic [AW-1:0]       pool_mem [POOL_DEPTH];

    logic [SW-1:0]       span;
    logic [SW-1:0]       left_full;
    logic [STATUS_W-1:0] cfg_status;
    logic                draw_ok;
    logic [AW:0]         fill_last;
    logic [AW:0]         trial;
    logic [AW:0]         trial_sub;
    logic [COUNT_W-1:0]  draws_inc;

    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_addr;
    logic [AW-1:0]       mem_wdata;

    assign span = {1'b0, range_end_reg} - {1'b0, range_start_reg} + SW'(1);
    assign left_full = span - SW'(draws_done_reg);
    assign fill_last = span[AW:0] - (AW+1)'(1);
    assign trial = {rem_reg, word_reg[WORD_W-1]};
    assign trial_sub = trial - left_reg;
    assign draws_inc = draws_done_reg + 1'b1;

    always_comb
    begin
        if (range_start_reg == '0 || range_end_reg == '0 || draw_count_reg == '0)
        begin
            cfg_status = ST_ZERO;
        end
        else if (range_end_reg <= range_start_reg)
        begin
            cfg_status = ST_RANGE;
        end
        else if (SW'(draw_count_reg) > span)
        begin
            cfg_status = ST_COUNT;
        end
        else if (span > SW'(POOL_DEPTH))
        begin
            cfg_status = ST_TOO_LARGE;
        end
        else
        begin
            cfg_status = ST_OK;
        end
    end

    assign draw_ok = run_valid_reg && (draws_done_reg < draw_count_reg)
                     && (SW'(draws_done_reg) < span) && (span <= SW'(POOL_DEPTH));

    assign flags.cfg_fail = (cfg_status != ST_OK);
    assign flags.draw_fail = !draw_ok;
    assign flags.fill_more = ({1'b0, cnt_reg} != fill_last);
    assign flags.mod_more = (mod_cnt_reg != MOD_CNT_W'(WORD_W - 1));

    assign result.drawn_value = value_reg;
    assign result.status = status_reg;
    assign result.last_draw = last_reg;

    // pool port select
    always_comb
    begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_addr = rem_reg;
        mem_wdata = rd_data_reg;
        unique case (ctl.op)
            OP_FILL:
            begin
                mem_we = 1'b1;
                mem_addr = cnt_reg;
                mem_wdata = cnt_reg;
            end
            OP_RD_PICK:
            begin
                mem_re = 1'b1;
                mem_addr = rem_reg;
            end
            OP_RD_TAIL:
            begin
                mem_re = 1'b1;
                mem_addr = tail_reg;
            end
            OP_WR_PICK:
            begin
                mem_we = 1'b1;
                mem_addr = rem_reg;
                mem_wdata = rd_data_reg;
            end
            OP_WR_TAIL:
            begin
                mem_we = 1'b1;
                mem_addr = tail_reg;
                mem_wdata = chosen_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pool_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= pool_mem[mem_addr];
        end
    end

    // configuration and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= VALUE_W'(1);
            range_end_reg <= VALUE_W'(2);
            draw_count_reg <= COUNT_W'(1);
            run_valid_reg <= 1'b0;
            draws_done_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RANGE_START:
                begin
                    range_start_reg <= cfg_data;
                    run_valid_reg <= 1'b0;
                end
                CFG_RANGE_END:
                begin
                    range_end_reg <= cfg_data;
                    run_valid_reg <= 1'b0;
                end
                CFG_DRAW_COUNT:
                begin
                    draw_count_reg <= cfg_data[COUNT_W-1:0];
                    run_valid_reg <= 1'b0;
                end
                default:
                begin
                    run_valid_reg <= run_valid_reg;
                end
            endcase
        end
        else
        begin
            case (ctl.op)
                OP_CHECK_CFG: run_valid_reg <= 1'b0;
                OP_START_RUN:
                begin
                    run_valid_reg <= 1'b1;
                    draws_done_reg <= '0;
                end
                OP_WR_TAIL: draws_done_reg <= draws_inc;
                default: draws_done_reg <= draws_done_reg;
            endcase
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_LATCH: word_reg <= random_word;
            OP_CHECK_CFG:
            begin
                status_reg <= cfg_status;
                value_reg <= '0;
                last_reg <= 1'b0;
                cnt_reg <= '0;
            end
            OP_FILL: cnt_reg <= cnt_reg + 1'b1;
            OP_CHECK_DRAW:
            begin
                status_reg <= draw_ok ? ST_OK : ST_EXHAUSTED;
                value_reg <= '0;
                last_reg <= 1'b0;
                left_reg <= left_full[AW:0];
                rem_reg <= '0;
                mod_cnt_reg <= '0;
            end
            OP_MOD_STEP:
            begin
                if (trial >= left_reg)
                begin
                    rem_reg <= trial_sub[AW-1:0];
                end
                else
                begin
                    rem_reg <= trial[AW-1:0];
                end
                word_reg <= {word_reg[WORD_W-2:0], 1'b0};
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
            OP_RD_PICK: tail_reg <= AW'(left_reg - (AW+1)'(1));
            OP_RD_TAIL: chosen_reg <= rd_data_reg;
            OP_WR_TAIL:
            begin
                value_reg <= range_start_reg + VALUE_W'(chosen_reg);
                last_reg <= (draws_inc == draw_count_reg);
            end
            default: last_reg <= last_reg;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/draw_without_replacement.sv */
// top level of the draw-without-replacement block
`timescale 1ns / 1ps
`default_nettype none

// Draws distinct values from range_start..range_end without replacement.
// A command transfer happens at a clock edge with start high and busy low;
// request carries the command (restart or draw) and a random word.
// Each command gives exactly one result: done is high for one cycle with
// result valid, and the receiver cannot hold it off.
// A restart checks the configuration and, when it is good, writes the
// offsets 0..range_end-range_start into the pool, one entry a cycle;
// on an error it goes straight to the result.
// A draw reduces the random word one bit a cycle, then reads the picked
// and the tail pool entries and writes them back swapped, on the single
// memory port; when no draw is left it goes straight to the result.
// A new command is taken in the cycle after done.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle;
// any write to one of the three registers ends the current run.
// After reset the registers hold 1, 2, 1 and no run is active; the pool
// holds nothing until a restart fills it.
module draw_without_replacement #(
    parameter int POOL_DEPTH = dwr_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire dwr_pkg::request_t               request,
    output logic                                 done,
    output dwr_pkg::result_t                     result,
    input  wire logic                            cfg_we,
    input  wire logic [dwr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dwr_pkg::VALUE_W-1:0]     cfg_data
);
    import dwr_pkg::*;

    ucode_t    ctl;
    dp_flags_t flags;

    dwr_useq u_useq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (request.command),
        .flags   (flags),
        .ctl     (ctl),
        .busy    (busy),
        .done    (done)
    );

    dwr_datapath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .random_word (request.random_word),
        .ctl         (ctl),
        .flags       (flags),
        .result      (result)
    );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// testbench for draw_without_replacement: shadow pool predictor, directed and random commands
`timescale 1ns / 1ps

module tb_top;
    import dwr_pkg::*;

    localparam int PERIOD = 8;
    localparam int POOL = POOL_DEPTH_DEF;
    localparam int OFFSET_W = $clog2(POOL);
    localparam int ITEMS = 1700;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    class pool_shadow;
        logic [VALUE_W-1:0]  low_value;
        logic [VALUE_W-1:0]  high_value;
        logic [COUNT_W-1:0]  run_length;
        logic [OFFSET_W-1:0] offsets [POOL];
        logic [COUNT_W-1:0]  drawn_so_far;
        bit                  run_active;
        result_t             owed [$];
        int unsigned         errors;

        function new();
            low_value = VALUE_W'(1);
            high_value = VALUE_W'(2);
            run_length = COUNT_W'(1);
            drawn_so_far = '0;
            run_active = 0;
            errors = 0;
            foreach (offsets[i])
                offsets[i] = '0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index, logic [VALUE_W-1:0] data);
            case (index)
                CFG_RANGE_START:
                begin
                    low_value = data;
                    run_active = 0;
                end
                CFG_RANGE_END:
                begin
                    high_value = data;
                    run_active = 0;
                end
                CFG_DRAW_COUNT:
                begin
                    run_length = data[COUNT_W-1:0];
                    run_active = 0;
                end
                default:
                    ;
            endcase
        endfunction

        function logic [VALUE_W:0] span_of_range();
            return {1'b0, high_value} - {1'b0, low_value} + 1;
        endfunction

        function logic [STATUS_W-1:0] restart_status();
            if (low_value == 0 || high_value == 0 || run_length == 0)
                return ST_ZERO;
            if (high_value <= low_value)
                return ST_RANGE;
            if (run_length > span_of_range())
                return ST_COUNT;
            if (span_of_range() > POOL)
                return ST_TOO_LARGE;
            return ST_OK;
        endfunction

        function void take_command(request_t req);
            result_t             r;
            logic [VALUE_W:0]    span;
            logic [COUNT_W-1:0]  left;
            logic [OFFSET_W-1:0] pick;
            logic [OFFSET_W-1:0] tail;
            logic [OFFSET_W-1:0] chosen;
            int                  i;
            r = '0;
            span = span_of_range();
            if (req.command == CMD_RESTART)
            begin
                r.status = restart_status();
                if (r.status != ST_OK)
                    run_active = 0;
                else
                begin
                    for (i = 0; i < span && i < POOL; i++)
                        offsets[i] = OFFSET_W'(i);
                    drawn_so_far = '0;
                    run_active = 1;
                end
            end
            else if (!run_active || drawn_so_far >= run_length || span > POOL
                     || drawn_so_far >= span)
                r.status = ST_EXHAUSTED;
            else
            begin
                left = COUNT_W'(span - {{(VALUE_W + 1 - COUNT_W){1'b0}}, drawn_so_far});
                pick = OFFSET_W'(req.random_word % left);
                tail = OFFSET_W'(left - 1'b1);
                chosen = offsets[pick];
                offsets[pick] = offsets[tail];
                offsets[tail] = chosen;
                drawn_so_far = drawn_so_far + 1'b1;
                r.status = ST_OK;
                r.drawn_value = low_value + VALUE_W'(chosen);
                r.last_draw = (drawn_so_far == run_length);
            end
            owed = {owed, r};
        endfunction

        function void report(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
            errors++;
            $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
        endfunction

        function void compare_result(result_t got);
            result_t want;
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none actual %0h/%0d/%0b", $time,
                         got.drawn_value, got.status, got.last_draw);
                return;
            end
            want = owed.pop_front();
            if (got.drawn_value !== want.drawn_value)
                report("drawn_value", want.drawn_value, got.drawn_value);
            if (got.status !== want.status)
                report("status", want.status, got.status);
            if (got.last_draw !== want.last_draw)
                report("last_draw", want.last_draw, got.last_draw);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    request_t               request;
    logic                   done;
    result_t                result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [VALUE_W-1:0]     cfg_data;

    pool_shadow  shadow = new();
    int unsigned sender_idle;
    int unsigned commands_sent;

    draw_without_replacement i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(1_000_000 * PERIOD);
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
        if (rst_n === 1'b1 && done === 1'b1)
            shadow.compare_result(result);

    function automatic logic [WORD_W-1:0] fresh_word();
        return WORD_W'($urandom_range(0, 32767));
    endfunction

    task automatic send_command(input logic cmd, input logic [WORD_W-1:0] word);
        request_t req;
        req.command = cmd;
        req.random_word = word;
        if (sender_idle != 0 && $urandom_range(99) < sender_idle)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle);
        end
        start <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        shadow.take_command(req);
        commands_sent++;
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (shadow.owed.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [VALUE_W-1:0] data);
        wait_quiet();
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow.write_register(index, data);
    endtask

    task automatic set_range(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi,
                             input logic [VALUE_W-1:0] count);
        write_register(CFG_RANGE_START, lo);
        write_register(CFG_RANGE_END, hi);
        write_register(CFG_DRAW_COUNT, count);
    endtask

    initial
    begin
        int unsigned          idle_levels [3];
        int unsigned          run;
        int unsigned          kind;
        int unsigned          span;
        int unsigned          count;
        int unsigned          draws;
        int unsigned          k;
        bit                   good;
        logic [VALUE_W-1:0]   lo;
        logic [VALUE_W-1:0]   hi;
        logic [CFG_INDEX_W-1:0] idx;

        idle_levels = '{0, 75, 10};
        sender_idle = 0;
        commands_sent = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        request <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset configuration, no run yet
        send_command(CMD_DRAW, 15'h0000);
        send_command(CMD_RESTART, 15'h7FFF);
        send_command(CMD_DRAW, 15'h7FFF);
        send_command(CMD_DRAW, 15'h1234);

        set_range(32'd0, 32'd9, 32'd1);
        send_command(CMD_RESTART, 15'h0000);
        send_command(CMD_DRAW, 15'h0001);
        set_range(32'd7, 32'd7, 32'd1);
        send_command(CMD_RESTART, 15'h0000);
        set_range(32'd8, 32'd3, 32'd1);
        send_command(CMD_RESTART, 15'h0000);
        set_range(32'd1, 32'd0, 32'd1);
        send_command(CMD_RESTART, 15'h0000);
        set_range(32'd3, 32'd6, 32'd5);
        send_command(CMD_RESTART, 15'h0000);
        set_range(32'd1, 32'd1025, 32'd1);
        send_command(CMD_RESTART, 15'h0000);
        set_range(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_RESTART, 15'h0000);
        set_range(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd2);
        send_command(CMD_RESTART, 15'h5555);
        send_command(CMD_DRAW, 15'h0000);
        send_command(CMD_DRAW, 15'h7FFF);
        send_command(CMD_DRAW, 15'h2AAA);
        set_range(32'd1, 32'd2, 32'd0);
        send_command(CMD_RESTART, 15'h0000);

        // register writes in the middle of a run
        set_range(32'd5, 32'd12, 32'd8);
        send_command(CMD_RESTART, 15'h0000);
        send_command(CMD_DRAW, 15'h7FFF);
        write_register(CFG_UNUSED, 32'hFFFF_FFFF);
        send_command(CMD_DRAW, 15'h0003);
        send_command(CMD_RESTART, 15'h0000);
        send_command(CMD_DRAW, 15'h0005);
        write_register(CFG_DRAW_COUNT, 32'd8);
        send_command(CMD_DRAW, 15'h0006);

        for (run = 0; commands_sent < ITEMS; run++)
        begin
            sender_idle = idle_levels[run % 3];
            kind = (run == 5) ? 100 : $urandom_range(99);
            good = 1;
            span = 2;
            count = 1;
            if (kind == 100)
            begin
                span = POOL;
                count = POOL;
            end
            else if (kind < 65)
            begin
                span = $urandom_range(2, 16);
                count = $urandom_range(1, span);
            end
            else if (kind < 80)
            begin
                span = $urandom_range(17, POOL);
                count = $urandom_range(1, 40);
            end
            else
                good = 0;

            if (good)
            begin
                lo = $urandom_range(1) ? $urandom_range(1, 100)
                                       : $urandom_range(1, 32'hFFFF_FFFF - span + 1);
                hi = lo + span - 1;
            end
            else
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        lo = $urandom();
                        hi = $urandom();
                        count = $urandom_range(2047);
                        case ($urandom_range(2))
                            0: lo = 0;
                            1: hi = 0;
                            default: count = 0;
                        endcase
                    end
                    1:
                    begin
                        lo = $urandom_range(1, 32'hFFFF_FFFF);
                        hi = $urandom_range(1, lo);
                        count = $urandom_range(1, 2047);
                    end
                    2:
                    begin
                        span = $urandom_range(2, 64);
                        lo = $urandom_range(1, 1000);
                        hi = lo + span - 1;
                        count = $urandom_range(span + 1, 2047);
                    end
                    default:
                    begin
                        lo = $urandom_range(1, 32'h7FFF_FFFF);
                        hi = lo + $urandom_range(POOL, 32'h7FFF_FFFF);
                        count = $urandom_range(1, 2047);
                    end
                endcase
            end

            set_range(lo, hi, count);
            if ($urandom_range(9) == 0)
                send_command(CMD_DRAW, fresh_word());
            send_command(CMD_RESTART, fresh_word());
            draws = good ? count + $urandom_range(0, 2) : $urandom_range(0, 2);
            for (k = 0; k < draws; k++)
            begin
                if ($urandom_range(59) == 0)
                    send_command(CMD_RESTART, fresh_word());
                else if ($urandom_range(59) == 0)
                begin
                    idx = CFG_INDEX_W'($urandom_range(3));
                    case (idx)
                        CFG_RANGE_START: write_register(idx, lo);
                        CFG_RANGE_END:   write_register(idx, hi);
                        CFG_DRAW_COUNT:  write_register(idx, count);
                        default:         write_register(idx, $urandom());
                    endcase
                end
                send_command(CMD_DRAW, fresh_word());
            end
        end

        wait_quiet();
        repeat (40) @(posedge clk);
        if (shadow.errors == 0 && shadow.owed.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* draw_without_replacement.f */
rtl/dwr_pkg.sv
rtl/dwr_useq.sv
rtl/dwr_datapath.sv
rtl/draw_without_replacement.sv
test/tb_top.sv
